// ===== src/adlf_pkg.sv =====
`timescale 1ns / 1ps
package adlf_pkg;

    localparam int MAX_LINE = 32;
    localparam int IDX_W    = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int LEN_W    = $clog2(MAX_LINE + 1);
    localparam int ADDR_W   = IDX_W + 1;
    localparam int CNT_W    = 32;

    localparam logic [7:0]       BYTE_NL  = 8'd10;
    localparam logic             CMD_DATA = 1'b0;
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_LINE);
    localparam logic [CNT_W-1:0] CNT_SAT  = '1;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic [CNT_W-1:0] run_count;
        logic             line_start;
        logic             last;
    } t_out_beat;

endpackage

// ===== src/adjacent_duplicate_line_filter.sv =====
`timescale 1ns / 1ps
// Adjacent duplicate line filter.
// Input channel (i_in_valid / o_in_stall): one beat is a data byte (i_command = 0)
// or an end-of-input flush (i_command = 1). Lines end at byte 10 or after
// MAX_LINE bytes. Output channel (o_out_valid / i_out_stall): one beat per byte
// of an emitted line, with the run count on the first byte when show_count is set
// and o_last on the final beat caused by an input beat.
// A data byte is accepted in S_IDLE, then compared in S_CMP against the stored
// line read from the line RAM. When a line differs from the stored one, the
// stored line is streamed out byte by byte via S_RD (RAM read, held until the
// output register is free) and S_WR (output load); a flush can stream two lines.
// Both lines live in one RAM as two banks that swap roles, so no copy is needed.
// Reset (synchronous, active low) clears the stream state and show_count; RAM
// contents are not cleared. If the receiver stalls, emission waits with the beat
// held in the output register; the input side stays stalled until emission ends.
module adjacent_duplicate_line_filter
    import adlf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_command,
    input  logic [7:0]       i_text_byte,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic [CNT_W-1:0] o_run_count,
    output logic             o_line_start,
    output logic             o_last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMP   = 3'd1;
    localparam logic [2:0] S_FLUSH = 3'd2;
    localparam logic [2:0] S_TAIL  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_WR    = 3'd5;

    logic [2:0]       r_state, n_state;
    logic             r_show;
    logic             r_bank, n_bank;          // bank holding the previous line
    logic [LEN_W-1:0] r_cur_len, n_cur_len;
    logic [LEN_W-1:0] r_prev_len, n_prev_len;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_have_prev, n_have_prev;
    logic             r_match, n_match;
    logic [7:0]       r_byte, n_byte;
    logic [LEN_W-1:0] r_ei, n_ei;
    logic             r_emit_last, n_emit_last;
    logic             r_final, n_final;        // emission ends the stream
    logic             r_flushing, n_flushing;

    logic              accept;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_rdata;
    logic              out_load, out_free;
    t_out_beat         out_beat;

    logic [LEN_W-1:0] len_inc;
    logic             match_new, line_done, cmp_equal, fl_equal, emit_done;
    logic [CNT_W-1:0] count_inc;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    assign len_inc   = r_cur_len + LEN_W'(1);
    assign match_new = r_match && r_have_prev && (r_cur_len < r_prev_len)
                       && (ram_rdata == r_byte);
    assign line_done = (r_byte == BYTE_NL) || (len_inc == LEN_MAX);
    assign cmp_equal = r_have_prev && match_new && (len_inc == r_prev_len);
    assign fl_equal  = r_have_prev && r_match && (r_cur_len == r_prev_len);
    assign count_inc = (r_count != CNT_SAT) ? r_count + CNT_W'(1) : r_count;
    assign emit_done = (r_ei + LEN_W'(1)) == r_prev_len;

    // write the current bank on a data-byte accept, read the previous bank for compare or emit
    assign ram_we    = accept && (i_command == CMD_DATA);
    assign ram_waddr = {~r_bank, r_cur_len[IDX_W-1:0]};
    assign ram_re    = ram_we || ((r_state == S_RD) && out_free);
    assign ram_raddr = (r_state == S_RD) ? {r_bank, r_ei[IDX_W-1:0]}
                                         : {r_bank, r_cur_len[IDX_W-1:0]};

    assign out_load            = (r_state == S_WR);
    assign out_beat.out_byte   = ram_rdata;
    assign out_beat.run_count  = ((r_ei == '0) && r_show) ? r_count : '0;
    assign out_beat.line_start = (r_ei == '0);
    assign out_beat.last       = r_emit_last && emit_done;

    always_comb begin
        n_state     = r_state;
        n_bank      = r_bank;
        n_cur_len   = r_cur_len;
        n_prev_len  = r_prev_len;
        n_count     = r_count;
        n_have_prev = r_have_prev;
        n_match     = r_match;
        n_byte      = r_byte;
        n_ei        = r_ei;
        n_emit_last = r_emit_last;
        n_final     = r_final;
        n_flushing  = r_flushing;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_byte  = i_text_byte;
                    n_state = (i_command == CMD_DATA) ? S_CMP : S_FLUSH;
                end
            end
            S_CMP: begin
                n_state = S_IDLE;
                if (!line_done) begin
                    n_cur_len = len_inc;
                    n_match   = match_new;
                end else if (!r_have_prev) begin
                    n_have_prev = 1'b1;
                    n_bank      = ~r_bank;
                    n_prev_len  = len_inc;
                    n_count     = CNT_W'(1);
                    n_cur_len   = '0;
                    n_match     = 1'b1;
                end else if (cmp_equal) begin
                    n_count   = count_inc;
                    n_cur_len = '0;
                    n_match   = 1'b1;
                end else begin
                    n_cur_len   = len_inc;
                    n_ei        = '0;
                    n_emit_last = 1'b1;
                    n_final     = 1'b0;
                    n_flushing  = 1'b0;
                    n_state     = S_RD;
                end
            end
            S_FLUSH: begin
                n_state = S_TAIL;
                if (r_cur_len != '0) begin
                    if (!r_have_prev) begin
                        n_have_prev = 1'b1;
                        n_bank      = ~r_bank;
                        n_prev_len  = r_cur_len;
                        n_count     = CNT_W'(1);
                        n_cur_len   = '0;
                        n_match     = 1'b1;
                    end else if (fl_equal) begin
                        n_count   = count_inc;
                        n_cur_len = '0;
                        n_match   = 1'b1;
                    end else begin
                        n_ei        = '0;
                        n_emit_last = 1'b0;
                        n_final     = 1'b0;
                        n_flushing  = 1'b1;
                        n_state     = S_RD;
                    end
                end
            end
            S_TAIL: begin
                if (r_have_prev) begin
                    n_ei        = '0;
                    n_emit_last = 1'b1;
                    n_final     = 1'b1;
                    n_flushing  = 1'b0;
                    n_state     = S_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                if (out_free) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                if (!emit_done) begin
                    n_ei    = r_ei + LEN_W'(1);
                    n_state = S_RD;
                end else if (r_final) begin
                    // end of stream: clear the stream state, keeping the bank
                    n_bank      = r_bank;
                    n_cur_len   = '0;
                    n_prev_len  = '0;
                    n_count     = '0;
                    n_have_prev = 1'b0;
                    n_match     = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    // new line replaces the emitted one
                    n_bank     = ~r_bank;
                    n_prev_len = r_cur_len;
                    n_count    = CNT_W'(1);
                    n_cur_len  = '0;
                    n_match    = 1'b1;
                    n_state    = r_flushing ? S_TAIL : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_show      <= 1'b0;
            r_bank      <= 1'b0;
            r_cur_len   <= '0;
            r_prev_len  <= '0;
            r_count     <= '0;
            r_have_prev <= 1'b0;
            r_match     <= 1'b1;
            r_ei        <= '0;
            r_emit_last <= 1'b0;
            r_final     <= 1'b0;
            r_flushing  <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_show <= i_cfg_data;
            end
            r_bank      <= n_bank;
            r_cur_len   <= n_cur_len;
            r_prev_len  <= n_prev_len;
            r_count     <= n_count;
            r_have_prev <= n_have_prev;
            r_match     <= n_match;
            r_ei        <= n_ei;
            r_emit_last <= n_emit_last;
            r_final     <= n_final;
            r_flushing  <= n_flushing;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    adlf_line_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_text_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    adlf_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (out_load),
        .i_beat       (out_beat),
        .i_out_stall  (i_out_stall),
        .o_free_next  (out_free),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_run_count  (o_run_count),
        .o_line_start (o_line_start),
        .o_last       (o_last)
    );

endmodule

// ===== src/adlf_line_ram.sv =====
`timescale 1ns / 1ps
// Two line banks, one write and one registered read port.
module adlf_line_ram
    import adlf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [2**ADDR_W];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/adlf_out_reg.sv =====
`timescale 1ns / 1ps
// Output register: holds one beat until the receiver takes it.
module adlf_out_reg
    import adlf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_out_beat        i_beat,
    input  logic             i_out_stall,
    output logic             o_free_next,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic [CNT_W-1:0] o_run_count,
    output logic             o_line_start,
    output logic             o_last
);

    logic      r_valid;
    t_out_beat r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= i_beat;
        end
    end

    // slot is empty next cycle unless something loads it
    assign o_free_next  = !r_valid || !i_out_stall;
    assign o_out_valid  = r_valid;
    assign o_out_byte   = r_beat.out_byte;
    assign o_run_count  = r_beat.run_count;
    assign o_line_start = r_beat.line_start;
    assign o_last       = r_beat.last;

endmodule
